### rtl/cmm_pkg.sv
// Shared constants, codes and item types for the complex matrix multiplier.
package cmm_pkg;

    // Sizes
    localparam int MAX_DIM   = 8;
    localparam int ELEM_BITS = 16;
    localparam int DIM_W     = $clog2(MAX_DIM);
    localparam int ADDR_W    = 2 * DIM_W;
    localparam int DEPTH     = MAX_DIM * MAX_DIM;
    localparam int PROD_BITS = 2 * ELEM_BITS;
    localparam int ACC_BITS  = 36;
    localparam int CFG_DIM_W = 4;
    localparam int CFG_IDX_W = 2;
    localparam int CMD_W     = 2;

    // Item commands
    localparam logic [CMD_W-1:0] CMD_WRITE_A = 2'd0;
    localparam logic [CMD_W-1:0] CMD_WRITE_B = 2'd1;
    localparam logic [CMD_W-1:0] CMD_COMPUTE = 2'd2;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_ROWS_A       = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_INNER_DIM    = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_COLS_B       = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_COMPLEX_MODE = 2'd3;

    typedef struct packed {
        logic [CMD_W-1:0]            cmd;
        logic [DIM_W-1:0]            row_index;
        logic [DIM_W-1:0]            col_index;
        logic signed [ELEM_BITS-1:0] elem_real;
        logic signed [ELEM_BITS-1:0] elem_imag;
    } in_item_t;

    typedef struct packed {
        logic [DIM_W-1:0]           out_row;
        logic [DIM_W-1:0]           out_col;
        logic signed [ACC_BITS-1:0] out_real;
        logic signed [ACC_BITS-1:0] out_imag;
        logic                       last;
    } out_item_t;

    // Clamped dimensions, held as last valid index
    typedef struct packed {
        logic [DIM_W-1:0] rows_last;
        logic [DIM_W-1:0] inner_last;
        logic [DIM_W-1:0] cols_last;
        logic             complex_mode;
    } cfg_t;

    // Controller to datapath
    typedef struct packed {
        logic             wr_a;
        logic             wr_b;
        logic             issue;
        logic [DIM_W-1:0] row;
        logic [DIM_W-1:0] col;
        logic [DIM_W-1:0] k;
        logic             first_k;
        logic             last_k;
        logic             last_elem;
    } dp_cmd_t;

    // Datapath to controller
    typedef struct packed {
        logic done;
    } dp_status_t;

endpackage

### rtl/cmm_cfg_regs.sv
// Configuration registers with dimension clamping.
module cmm_cfg_regs
    import cmm_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [CFG_DIM_W-1:0] cfg_data,
    output cfg_t                 cfg
);

    logic [CFG_DIM_W-1:0] rows_a_reg;
    logic [CFG_DIM_W-1:0] inner_dim_reg;
    logic [CFG_DIM_W-1:0] cols_b_reg;
    logic                 complex_mode_reg;

    // 0 acts as 1, anything above MAX_DIM acts as MAX_DIM
    function automatic logic [DIM_W-1:0] last_index(input logic [CFG_DIM_W-1:0] d);
        logic [CFG_DIM_W-1:0] dm1;
        dm1 = d - 1'b1;
        if (d == '0)
            return '0;
        else if (d > CFG_DIM_W'(MAX_DIM))
            return DIM_W'(MAX_DIM - 1);
        else
            return dm1[DIM_W-1:0];
    endfunction

    assign cfg_ready = 1'b1;

    // Register writes
    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n)
        begin
            rows_a_reg       <= CFG_DIM_W'(MAX_DIM);
            inner_dim_reg    <= CFG_DIM_W'(MAX_DIM);
            cols_b_reg       <= CFG_DIM_W'(MAX_DIM);
            complex_mode_reg <= 1'b0;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                CFG_ROWS_A:       rows_a_reg       <= cfg_data;
                CFG_INNER_DIM:    inner_dim_reg    <= cfg_data;
                CFG_COLS_B:       cols_b_reg       <= cfg_data;
                CFG_COMPLEX_MODE: complex_mode_reg <= cfg_data[0];
                default:          ;
            endcase
        end
    end

    assign cfg.rows_last    = last_index(rows_a_reg);
    assign cfg.inner_last   = last_index(inner_dim_reg);
    assign cfg.cols_last    = last_index(cols_b_reg);
    assign cfg.complex_mode = complex_mode_reg;

endmodule

### rtl/cmm_ctrl.sv
// Controller: item decode, write range check and the i/j/k loop sequencer.
module cmm_ctrl
    import cmm_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       start,
    input  in_item_t   item,
    input  cfg_t       cfg,
    input  dp_status_t status,
    output logic       busy,
    output dp_cmd_t    cmd
);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_RUN,
        ST_DRAIN
    } state_t;

    state_t           state_reg, state_next;
    logic             busy_reg, busy_next;
    logic [DIM_W-1:0] i_reg, i_next;
    logic [DIM_W-1:0] j_reg, j_next;
    logic [DIM_W-1:0] k_reg, k_next;
    logic             accept;

    assign accept = start && !busy_reg;
    assign busy   = busy_reg;

    // Element writes go straight to the stores, out-of-range ones dropped
    assign cmd.wr_a = accept && (item.cmd == CMD_WRITE_A)
                      && (item.row_index <= cfg.rows_last)
                      && (item.col_index <= cfg.inner_last);
    assign cmd.wr_b = accept && (item.cmd == CMD_WRITE_B)
                      && (item.row_index <= cfg.inner_last)
                      && (item.col_index <= cfg.cols_last);

    // One term issued per cycle while running
    assign cmd.issue     = (state_reg == ST_RUN);
    assign cmd.row       = i_reg;
    assign cmd.col       = j_reg;
    assign cmd.k         = k_reg;
    assign cmd.first_k   = (k_reg == '0);
    assign cmd.last_k    = (k_reg == cfg.inner_last);
    assign cmd.last_elem = (i_reg == cfg.rows_last) && (j_reg == cfg.cols_last);

    // Next state and loop counters
    always_comb begin
        state_next = state_reg;
        busy_next  = busy_reg;
        i_next     = i_reg;
        j_next     = j_reg;
        k_next     = k_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (accept && (item.cmd == CMD_COMPUTE))
                begin
                    state_next = ST_RUN;
                    busy_next  = 1'b1;
                    i_next     = '0;
                    j_next     = '0;
                    k_next     = '0;
                end
            end
            ST_RUN:
            begin
                if (k_reg == cfg.inner_last)
                begin
                    k_next = '0;
                    if (j_reg == cfg.cols_last)
                    begin
                        j_next = '0;
                        if (i_reg == cfg.rows_last)
                            state_next = ST_DRAIN;
                        else
                            i_next = i_reg + 1'b1;
                    end
                    else
                    begin
                        j_next = j_reg + 1'b1;
                    end
                end
                else
                begin
                    k_next = k_reg + 1'b1;
                end
            end
            ST_DRAIN:
            begin
                // wait for the final element to leave the pipeline
                if (status.done)
                begin
                    state_next = ST_IDLE;
                    busy_next  = 1'b0;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
                busy_next  = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            busy_reg  <= 1'b0;
            i_reg     <= '0;
            j_reg     <= '0;
            k_reg     <= '0;
        end
        else
        begin
            state_reg <= state_next;
            busy_reg  <= busy_next;
            i_reg     <= i_next;
            j_reg     <= j_next;
            k_reg     <= k_next;
        end
    end

endmodule

### rtl/cmm_datapath.sv
// Datapath: element stores, complex multiply stage and accumulator.
module cmm_datapath
    import cmm_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  in_item_t   item,
    input  cfg_t       cfg,
    input  dp_cmd_t    cmd,
    output out_item_t  result,
    output logic       result_valid,
    output dp_status_t status
);

    typedef struct packed {
        logic signed [ELEM_BITS-1:0] re;
        logic signed [ELEM_BITS-1:0] im;
    } elem_t;

    typedef struct packed {
        logic [DIM_W-1:0] row;
        logic [DIM_W-1:0] col;
        logic             first_k;
        logic             last_k;
        logic             last_elem;
    } tag_t;

    elem_t mem_a [DEPTH];
    elem_t mem_b [DEPTH];
    elem_t rd_a_reg;
    elem_t rd_b_reg;

    logic s1_valid_reg, s2_valid_reg;
    tag_t s1_tag_reg, s2_tag_reg;
    tag_t s0_tag;

    logic signed [PROD_BITS-1:0] p_rr_reg, p_ii_reg, p_ri_reg, p_ir_reg;
    logic signed [ACC_BITS-1:0]  acc_re_reg, acc_im_reg;
    logic signed [ACC_BITS-1:0]  acc_re_next, acc_im_next;
    logic signed [ACC_BITS-1:0]  term_re, term_im;

    out_item_t result_reg;
    logic      result_valid_reg;

    function automatic logic signed [ACC_BITS-1:0] ext_prod(
        input logic signed [PROD_BITS-1:0] p
    );
        return {{(ACC_BITS - PROD_BITS){p[PROD_BITS-1]}}, p};
    endfunction

    assign s0_tag.row       = cmd.row;
    assign s0_tag.col       = cmd.col;
    assign s0_tag.first_k   = cmd.first_k;
    assign s0_tag.last_k    = cmd.last_k;
    assign s0_tag.last_elem = cmd.last_elem;

    // Store A: written at (row, col), read at (i, k)
    always_ff @(posedge clk) begin
        if (cmd.wr_a)
            mem_a[{item.row_index, item.col_index}] <= '{re: item.elem_real,
                                                         im: item.elem_imag};
        rd_a_reg <= mem_a[{cmd.row, cmd.k}];
    end

    // Store B: written at (row, col), read at (k, j)
    always_ff @(posedge clk) begin
        if (cmd.wr_b)
            mem_b[{item.row_index, item.col_index}] <= '{re: item.elem_real,
                                                         im: item.elem_imag};
        rd_b_reg <= mem_b[{cmd.k, cmd.col}];
    end

    // Pipeline valid bits
    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n)
        begin
            s1_valid_reg     <= 1'b0;
            s2_valid_reg     <= 1'b0;
            result_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg     <= cmd.issue;
            s2_valid_reg     <= s1_valid_reg;
            result_valid_reg <= s2_valid_reg && s2_tag_reg.last_k;
        end
    end

    // Tags and the four partial products
    always_ff @(posedge clk) begin
        s1_tag_reg <= s0_tag;
        s2_tag_reg <= s1_tag_reg;
        p_rr_reg   <= PROD_BITS'(rd_a_reg.re) * PROD_BITS'(rd_b_reg.re);
        p_ii_reg   <= PROD_BITS'(rd_a_reg.im) * PROD_BITS'(rd_b_reg.im);
        p_ri_reg   <= PROD_BITS'(rd_a_reg.re) * PROD_BITS'(rd_b_reg.im);
        p_ir_reg   <= PROD_BITS'(rd_a_reg.im) * PROD_BITS'(rd_b_reg.re);
    end

    // Term of one k step; imaginary parts drop out in real mode
    always_comb begin
        term_re = ext_prod(p_rr_reg) - (cfg.complex_mode ? ext_prod(p_ii_reg) : '0);
        term_im = cfg.complex_mode ? (ext_prod(p_ri_reg) + ext_prod(p_ir_reg)) : '0;
        acc_re_next = (s2_tag_reg.first_k ? '0 : acc_re_reg) + term_re;
        acc_im_next = (s2_tag_reg.first_k ? '0 : acc_im_reg) + term_im;
    end

    // Accumulator and output register
    always_ff @(posedge clk) begin
        if (s2_valid_reg)
        begin
            acc_re_reg <= acc_re_next;
            acc_im_reg <= acc_im_next;
            if (s2_tag_reg.last_k)
            begin
                result_reg.out_row  <= s2_tag_reg.row;
                result_reg.out_col  <= s2_tag_reg.col;
                result_reg.out_real <= acc_re_next;
                result_reg.out_imag <= acc_im_next;
                result_reg.last     <= s2_tag_reg.last_elem;
            end
        end
    end

    assign result       = result_reg;
    assign result_valid = result_valid_reg;
    assign status.done  = result_valid_reg && result_reg.last;

endmodule

### rtl/complex_matrix_multiply.sv
// Write items: busy stays low, one item per cycle while busy is low.
// Compute item: one k term per cycle through the A/B store read ports; each
// product element appears as a result strobe once its last k term is summed,
// and busy drops the cycle after the last strobe. No stalls.
// Reset clears configuration to 8/8/8/real and the sequencer; stores keep data.
module complex_matrix_multiply
    import cmm_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 start,
    output logic                 busy,
    input  in_item_t             item,
    output logic                 result_valid,
    output out_item_t            result,
    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [CFG_DIM_W-1:0] cfg_data
);

    cfg_t       cfg;
    dp_cmd_t    dp_cmd;
    dp_status_t dp_status;

    cmm_cfg_regs u_cfg_regs (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    cmm_ctrl u_ctrl (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (start),
        .item   (item),
        .cfg    (cfg),
        .status (dp_status),
        .busy   (busy),
        .cmd    (dp_cmd)
    );

    cmm_datapath u_datapath (
        .clk          (clk),
        .rst_n        (rst_n),
        .item         (item),
        .cfg          (cfg),
        .cmd          (dp_cmd),
        .result       (result),
        .result_valid (result_valid),
        .status       (dp_status)
    );

endmodule
